// File: rtl/mips_subset_execute_unit_defines.svh
// assertion macros for the mips subset execute unit
// used by mips_subset_execute_unit.sv; expects clk and rst in scope
`ifndef MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, checking suspended during reset
`define MSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checking suspended during reset
`define MSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mse_pkg.sv
// types, opcode and status constants for the mips subset execute unit
// no dependencies; used by mips_subset_execute_unit.sv
package mse_pkg;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'b000000;
  localparam logic [5:0] OP_J       = 6'b000010;
  localparam logic [5:0] OP_JAL     = 6'b000011;
  localparam logic [5:0] OP_BEQ     = 6'b000100;
  localparam logic [5:0] OP_BNE     = 6'b000101;
  localparam logic [5:0] OP_ADDI    = 6'b001000;
  localparam logic [5:0] OP_SLTI    = 6'b001010;
  localparam logic [5:0] OP_ANDI    = 6'b001100;
  localparam logic [5:0] OP_ORI     = 6'b001101;
  localparam logic [5:0] OP_LUI     = 6'b001111;
  localparam logic [5:0] OP_LW      = 6'b100011;
  localparam logic [5:0] OP_SW      = 6'b101011;

  // special function codes
  localparam logic [5:0] FN_SLL     = 6'b000000;
  localparam logic [5:0] FN_SRL     = 6'b000010;
  localparam logic [5:0] FN_JR      = 6'b001000;
  localparam logic [5:0] FN_SYSCALL = 6'b001100;
  localparam logic [5:0] FN_ADD     = 6'b100000;
  localparam logic [5:0] FN_SUB     = 6'b100010;
  localparam logic [5:0] FN_AND     = 6'b100100;
  localparam logic [5:0] FN_OR      = 6'b100101;
  localparam logic [5:0] FN_NOR     = 6'b100111;
  localparam logic [5:0] FN_SLT     = 6'b101010;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNKNOWN     = 3'd1;
  localparam logic [2:0] ST_PRINT_INT   = 3'd2;
  localparam logic [2:0] ST_DUMP        = 3'd3;
  localparam logic [2:0] ST_EXIT        = 3'd4;
  localparam logic [2:0] ST_READ_INT    = 3'd5;
  localparam logic [2:0] ST_BAD_SYSCALL = 3'd6;

  // syscall service numbers held in v0
  localparam logic [31:0] SVC_DUMP      = 32'd0;
  localparam logic [31:0] SVC_PRINT_INT = 32'd1;
  localparam logic [31:0] SVC_READ_INT  = 32'd5;
  localparam logic [31:0] SVC_EXIT      = 32'd10;

  // special registers
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_V0   = 5'd2;
  localparam logic [4:0] REG_A0   = 5'd4;
  localparam logic [4:0] REG_GP   = 5'd28;
  localparam logic [4:0] REG_SP   = 5'd29;
  localparam logic [4:0] REG_RA   = 5'd31;

  localparam logic [31:0] GP_RESET = 32'd4000;
  localparam logic [31:0] SP_RESET = 32'd12000;

  // register writeback carried from execute into the writeback stage
  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] val;
    logic        load;
    logic        in_range;
  } wb_t;

  // one result item
  typedef struct packed {
    logic [31:0] next_pc;
    logic [2:0]  status;
    logic [31:0] arg;
  } result_t;

  // register file contents after reset
  function automatic logic [31:0] gpr_reset_value(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      REG_GP:  v = GP_RESET;
      REG_SP:  v = SP_RESET;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/mips_subset_execute_unit.sv
// mips32 subset execute unit: register file, data memory, pc and result queue
// depends on mse_pkg.sv and mips_subset_execute_unit_defines.svh
//
// channel   direction  fields                          transfer when
// in        input      instr_word                      in_valid && in_ready
// out       output     next_pc, status, service_arg    out_valid && out_ready
//
// one instruction per cycle while in_ready is high: register read at the in
// transfer, execute the next cycle, result queued at its end; loads write back
// the cycle after execute and are forwarded. after reset a clearing pass zeroes
// the data memory, in_ready stays low meanwhile. a two-entry result queue absorbs
// out stalls; in_ready drops once the queue plus execute stage would overflow.
`include "mips_subset_execute_unit_defines.svh"

module mips_subset_execute_unit #(
  parameter int DATA_WORDS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        instr_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        next_pc,
  output logic [2:0]         status,
  output logic signed [31:0] service_arg
);

  localparam int AW = $clog2(DATA_WORDS);

  // transfers
  logic in_xfer;
  logic out_xfer;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // data memory clearing pass after reset
  logic          clr_busy;
  logic [AW-1:0] clr_idx;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == AW'(DATA_WORDS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // register file memory with two read ports
  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid;
  logic [31:0] rs_q;
  logic [31:0] rt_q;
  logic        rs_v_q;
  logic        rt_v_q;
  logic        rf_we;
  logic [4:0]  rf_widx;
  logic [31:0] wb_val;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_widx] <= wb_val;
    end
    if (in_xfer) begin
      rs_q   <= rf_mem[instr_word[25:21]];
      rt_q   <= rf_mem[instr_word[20:16]];
      rs_v_q <= rf_valid[instr_word[25:21]];
      rt_v_q <= rf_valid[instr_word[20:16]];
    end
  end

  // entries read as their reset value until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[rf_widx] <= 1'b1;
    end
  end

  // shadow copies of v0 and a0 for syscall decode
  logic [31:0] v0_q;
  logic [31:0] a0_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0_q <= '0;
      a0_q <= '0;
    end else if (rf_we) begin
      if (rf_widx == mse_pkg::REG_V0) begin
        v0_q <= wb_val;
      end
      if (rf_widx == mse_pkg::REG_A0) begin
        a0_q <= wb_val;
      end
    end
  end

  // write that landed at the same edge as the current operand read
  logic        wbp_en;
  logic [4:0]  wbp_idx;
  logic [31:0] wbp_val;
  always_ff @(posedge clk) begin
    if (rst) begin
      wbp_en <= 1'b0;
    end else begin
      wbp_en <= rf_we;
    end
    wbp_idx <= rf_widx;
    wbp_val <= wb_val;
  end

  // execute stage registers
  logic        s1_valid;
  logic [31:0] s1_instr;
  logic [31:0] pc;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_xfer;
    end
    if (in_xfer) begin
      s1_instr <= instr_word;
    end
  end

  // instruction fields
  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [5:0]  fn;
  logic [15:0] imm;
  assign op  = s1_instr[31:26];
  assign rs  = s1_instr[25:21];
  assign rt  = s1_instr[20:16];
  assign rd  = s1_instr[15:11];
  assign sh  = s1_instr[10:6];
  assign fn  = s1_instr[5:0];
  assign imm = s1_instr[15:0];

  // operand forwarding: writeback stage first, then the write at the read edge
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] v0;
  always_comb begin
    a = rs_v_q ? rs_q : mse_pkg::gpr_reset_value(rs);
    if (wbp_en && wbp_idx == rs) begin
      a = wbp_val;
    end
    if (rf_we && rf_widx == rs) begin
      a = wb_val;
    end
    b = rt_v_q ? rt_q : mse_pkg::gpr_reset_value(rt);
    if (wbp_en && wbp_idx == rt) begin
      b = wbp_val;
    end
    if (rf_we && rf_widx == rt) begin
      b = wb_val;
    end
    v0 = (rf_we && rf_widx == mse_pkg::REG_V0) ? wb_val : v0_q;
  end

  // shared address and immediate arithmetic
  logic [31:0] imm_s;
  logic [31:0] imm_z;
  logic [31:0] ea;
  logic [31:0] pc4;
  logic [31:0] pc8;
  logic [31:0] br_target;
  logic [31:0] j_target;
  logic        ea_in_range;
  assign imm_s       = {{16{imm[15]}}, imm};
  assign imm_z       = {16'd0, imm};
  assign ea          = a + imm_s;
  assign pc4         = pc + 32'd4;
  assign pc8         = pc + 32'd8;
  assign br_target   = pc4 + {imm_s[29:0], 2'b00};
  assign j_target    = {pc4[31:28], s1_instr[25:0], 2'b00};
  assign ea_in_range = ea[31:2] < 30'(DATA_WORDS);

  // decode and execute
  logic [31:0] npc;
  logic [2:0]  st;
  logic [31:0] arg;
  logic        we;
  logic [4:0]  widx;
  logic [31:0] wval;
  logic        is_load;
  logic        is_store;
  always_comb begin
    npc      = pc4;
    st       = mse_pkg::ST_OK;
    arg      = '0;
    we       = 1'b0;
    widx     = rd;
    wval     = '0;
    is_load  = 1'b0;
    is_store = 1'b0;
    case (op)
      mse_pkg::OP_SPECIAL: begin
        case (fn)
          mse_pkg::FN_ADD: begin
            we = 1'b1; wval = a + b;
          end
          mse_pkg::FN_SUB: begin
            we = 1'b1; wval = a - b;
          end
          mse_pkg::FN_AND: begin
            we = 1'b1; wval = a & b;
          end
          mse_pkg::FN_OR: begin
            we = 1'b1; wval = a | b;
          end
          mse_pkg::FN_NOR: begin
            we = 1'b1; wval = ~(a | b);
          end
          mse_pkg::FN_SLT: begin
            we = 1'b1; wval = {31'd0, $signed(a) < $signed(b)};
          end
          mse_pkg::FN_SLL: begin
            we = 1'b1; wval = b << sh;
          end
          mse_pkg::FN_SRL: begin
            we = 1'b1; wval = b >> sh;
          end
          mse_pkg::FN_JR: begin
            npc = a;
          end
          mse_pkg::FN_SYSCALL: begin
            case (v0)
              mse_pkg::SVC_PRINT_INT: begin
                st  = mse_pkg::ST_PRINT_INT;
                arg = (rf_we && rf_widx == mse_pkg::REG_A0) ? wb_val : a0_q;
              end
              mse_pkg::SVC_DUMP:     st = mse_pkg::ST_DUMP;
              mse_pkg::SVC_EXIT:     st = mse_pkg::ST_EXIT;
              mse_pkg::SVC_READ_INT: st = mse_pkg::ST_READ_INT;
              default:               st = mse_pkg::ST_BAD_SYSCALL;
            endcase
          end
          default: st = mse_pkg::ST_UNKNOWN;
        endcase
      end
      mse_pkg::OP_J: begin
        npc = j_target;
      end
      mse_pkg::OP_JAL: begin
        npc  = j_target;
        we   = 1'b1;
        widx = mse_pkg::REG_RA;
        wval = pc8;
      end
      mse_pkg::OP_BEQ: begin
        if (a == b) begin
          npc = br_target;
        end
      end
      mse_pkg::OP_BNE: begin
        if (a != b) begin
          npc = br_target;
        end
      end
      mse_pkg::OP_ADDI: begin
        we = 1'b1; widx = rt; wval = ea;
      end
      mse_pkg::OP_SLTI: begin
        we = 1'b1; widx = rt; wval = {31'd0, $signed(a) < $signed(imm_s)};
      end
      mse_pkg::OP_ANDI: begin
        we = 1'b1; widx = rt; wval = a & imm_z;
      end
      mse_pkg::OP_ORI: begin
        we = 1'b1; widx = rt; wval = a | imm_z;
      end
      mse_pkg::OP_LUI: begin
        we = 1'b1; widx = rt; wval = {imm, 16'd0};
      end
      mse_pkg::OP_LW: begin
        we = 1'b1; widx = rt; is_load = 1'b1;
      end
      mse_pkg::OP_SW: begin
        is_store = ea_in_range;
      end
      default: st = mse_pkg::ST_UNKNOWN;
    endcase
  end

  // program counter follows every executed instruction
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (s1_valid) begin
      pc <= npc;
    end
  end

  // data memory: clearing pass or store, and load read
  logic [31:0]   dm_mem [DATA_WORDS];
  logic [31:0]   dm_q;
  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0]   dm_wdata;
  logic          dm_re;
  assign dm_we    = clr_busy || (s1_valid && is_store);
  assign dm_waddr = clr_busy ? clr_idx : ea[AW+1:2];
  assign dm_wdata = clr_busy ? 32'd0 : b;
  assign dm_re    = s1_valid && is_load && ea_in_range;

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      dm_q <= dm_mem[ea[AW+1:2]];
    end
  end

  // writeback stage
  mse_pkg::wb_t s2;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.en <= 1'b0;
    end else begin
      s2.en <= s1_valid && we && (widx != mse_pkg::REG_ZERO);
    end
    s2.idx      <= widx;
    s2.val      <= wval;
    s2.load     <= is_load;
    s2.in_range <= ea_in_range;
  end

  assign rf_we   = s2.en;
  assign rf_widx = s2.idx;
  assign wb_val  = s2.load ? (s2.in_range ? dm_q : 32'd0) : s2.val;

  // two-entry result queue
  mse_pkg::result_t q_mem [2];
  mse_pkg::result_t q_head;
  logic             q_wptr;
  logic             q_rptr;
  logic [1:0]       q_count;
  logic [2:0]       occ_after;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q_mem[q_wptr] <= '{next_pc: npc, status: st, arg: arg};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wptr  <= 1'b0;
      q_rptr  <= 1'b0;
      q_count <= '0;
    end else begin
      if (s1_valid) begin
        q_wptr <= ~q_wptr;
      end
      if (out_xfer) begin
        q_rptr <= ~q_rptr;
      end
      q_count <= 2'(q_count + {1'b0, s1_valid} - {1'b0, out_xfer});
    end
  end

  // accept only if the queue can take this item's result next cycle
  assign occ_after = {1'b0, q_count} + {2'd0, s1_valid} - {2'd0, out_xfer};
  assign in_ready  = !clr_busy && (occ_after <= 3'd1);

  assign q_head      = q_mem[q_rptr];
  assign out_valid   = q_count != 2'd0;
  assign next_pc     = q_head.next_pc;
  assign status      = q_head.status;
  assign service_arg = $signed(q_head.arg);

  // checks
  `MSE_ASSERT_SAME(a_queue_room, s1_valid && !out_xfer, q_count != 2'd2, "result queue overflow")
  `MSE_ASSERT_SAME(a_no_r0_write, rf_we, rf_widx != mse_pkg::REG_ZERO, "write to register zero")
  `MSE_ASSERT_SAME(a_clear_alone, clr_busy, !s1_valid && !s2.en, "instruction during clear")
  `MSE_ASSERT_NEXT(a_issue, in_xfer, s1_valid, "accepted instruction not executed")

endmodule

// File: dv/mse_result_checker.sv
`timescale 1ns / 1ps
// result checker for mips_subset_execute_unit: mirrors the core state and compares
// each transfer on the out channel with the predicted next pc, status and argument
// depends on mse_pkg.sv
module mse_result_checker #(
  parameter int DATA_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] instr_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] next_pc,
  input  logic [2:0]  status,
  input  logic [31:0] service_arg,
  output int          errors,
  output int          inflight
);

  localparam int AW = $clog2(DATA_WORDS);

  // shadow copy of the architectural state
  logic [31:0] gpr [32];
  logic [31:0] pc;
  logic [31:0] dmem [DATA_WORDS];

  // results of retired instructions, oldest first
  mse_pkg::result_t retired_q [$];
  mse_pkg::result_t oldest;

  function automatic void write_gpr(input logic [4:0] idx, input logic [31:0] val);
    if (idx != mse_pkg::REG_ZERO) gpr[idx] = val;
  endfunction

  // execute one instruction on the shadow state and return its result
  function automatic mse_pkg::result_t retire_instr(input logic [31:0] w);
    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc4;
    logic [31:0] npc;
    logic [31:0] simm;
    logic [31:0] zimm;
    logic [31:0] jtarget;
    logic [31:0] addr;
    logic [31:0] rdata;
    logic [2:0]  st;
    logic [31:0] arg;
    mse_pkg::result_t r;
    opc = w[31:26];
    rs = w[25:21];
    rt = w[20:16];
    rd = w[15:11];
    sh = w[10:6];
    fn = w[5:0];
    a = gpr[rs];
    b = gpr[rt];
    pc4 = pc + 32'd4;
    npc = pc4;
    st = mse_pkg::ST_OK;
    arg = '0;
    simm = {{16{w[15]}}, w[15:0]};
    zimm = {16'h0000, w[15:0]};
    jtarget = {pc4[31:28], w[25:0], 2'b00};
    addr = a + simm;
    case (opc)
      mse_pkg::OP_SPECIAL: begin
        case (fn)
          mse_pkg::FN_ADD: write_gpr(rd, a + b);
          mse_pkg::FN_SUB: write_gpr(rd, a - b);
          mse_pkg::FN_AND: write_gpr(rd, a & b);
          mse_pkg::FN_OR:  write_gpr(rd, a | b);
          mse_pkg::FN_NOR: write_gpr(rd, ~(a | b));
          mse_pkg::FN_SLT: write_gpr(rd, {31'd0, $signed(a) < $signed(b)});
          mse_pkg::FN_SLL: write_gpr(rd, b << sh);
          mse_pkg::FN_SRL: write_gpr(rd, b >> sh);
          mse_pkg::FN_JR:  npc = a;
          // service picked by v0, nothing is performed
          mse_pkg::FN_SYSCALL: begin
            case (gpr[mse_pkg::REG_V0])
              mse_pkg::SVC_PRINT_INT: begin
                st = mse_pkg::ST_PRINT_INT;
                arg = gpr[mse_pkg::REG_A0];
              end
              mse_pkg::SVC_DUMP:     st = mse_pkg::ST_DUMP;
              mse_pkg::SVC_EXIT:     st = mse_pkg::ST_EXIT;
              mse_pkg::SVC_READ_INT: st = mse_pkg::ST_READ_INT;
              default:               st = mse_pkg::ST_BAD_SYSCALL;
            endcase
          end
          default: st = mse_pkg::ST_UNKNOWN;
        endcase
      end
      mse_pkg::OP_J: npc = jtarget;
      mse_pkg::OP_JAL: begin
        write_gpr(mse_pkg::REG_RA, pc + 32'd8);
        npc = jtarget;
      end
      mse_pkg::OP_BEQ: if (a == b) npc = pc4 + (simm << 2);
      mse_pkg::OP_BNE: if (a != b) npc = pc4 + (simm << 2);
      mse_pkg::OP_ADDI: write_gpr(rt, a + simm);
      mse_pkg::OP_SLTI: write_gpr(rt, {31'd0, $signed(a) < $signed(simm)});
      mse_pkg::OP_ANDI: write_gpr(rt, a & zimm);
      mse_pkg::OP_ORI:  write_gpr(rt, a | zimm);
      mse_pkg::OP_LUI:  write_gpr(rt, {w[15:0], 16'h0000});
      // word index beyond the memory reads zero
      mse_pkg::OP_LW: begin
        rdata = '0;
        if (addr[31:2] < DATA_WORDS) rdata = dmem[addr[AW+1:2]];
        write_gpr(rt, rdata);
      end
      // word index beyond the memory drops the store
      mse_pkg::OP_SW: if (addr[31:2] < DATA_WORDS) dmem[addr[AW+1:2]] = b;
      default: st = mse_pkg::ST_UNKNOWN;
    endcase
    pc = npc;
    r.next_pc = npc;
    r.status = st;
    r.arg = arg;
    return r;
  endfunction

  // watch both channels; results are matched before the new instruction is queued
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      gpr[mse_pkg::REG_GP] = mse_pkg::GP_RESET;
      gpr[mse_pkg::REG_SP] = mse_pkg::SP_RESET;
      for (int i = 0; i < DATA_WORDS; i++) dmem[i] = '0;
      pc = '0;
      retired_q.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (retired_q.size() == 0) begin
          $display("%0t: unexpected result next_pc %h status %0d arg %h", $time,
                   next_pc, status, service_arg);
          errors++;
        end else begin
          oldest = retired_q.pop_front();
          if (next_pc !== oldest.next_pc) begin
            $display("%0t: next_pc expected %h actual %h", $time, oldest.next_pc, next_pc);
            errors++;
          end
          if (status !== oldest.status) begin
            $display("%0t: status expected %0d actual %0d", $time, oldest.status, status);
            errors++;
          end
          if (service_arg !== oldest.arg) begin
            $display("%0t: service_arg expected %h actual %h", $time, oldest.arg,
                     service_arg);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) retired_q.push_back(retire_instr(instr_word));
    end
    inflight = retired_q.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// top of the testbench for mips_subset_execute_unit: clock, reset, instruction
// stream and result-side stalls; depends on mse_pkg.sv and mse_result_checker.sv
module tb;

  localparam int DATA_WORDS  = 4096;
  localparam int TOTAL_ITEMS = 1450;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_WAIT  = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] instr_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] next_pc;
  logic [2:0]  status;
  logic signed [31:0] service_arg;

  int errors;
  int inflight;
  int instr_sent = 0;
  int hold_left = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  mips_subset_execute_unit #(.DATA_WORDS(DATA_WORDS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .instr_word(instr_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_pc(next_pc), .status(status), .service_arg(service_arg)
  );

  mse_result_checker #(.DATA_WORDS(DATA_WORDS)) result_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .instr_word(instr_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_pc(next_pc), .status(status), .service_arg(service_arg),
    .errors(errors), .inflight(inflight)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // instruction encoders
  function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sh,
                                        input logic [5:0] fn);
    return {mse_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] jtype(input logic [5:0] op, input logic [25:0] target);
    return {op, target};
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [4:0] rand_reg();
    logic [4:0] r;
    r = 5'($urandom_range(1, 31));
    if ($urandom_range(0, 7) == 0) r = mse_pkg::REG_ZERO;
    return r;
  endfunction

  // one transfer on the in channel after a random gap
  task automatic send_instr(input logic [31:0] w);
    int gap;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    instr_word <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    instr_sent++;
  endtask

  // one random instruction, or a short syscall sequence
  task automatic send_random();
    int          pick;
    logic [31:0] rnd;
    logic [15:0] imm;
    logic [15:0] svc;
    logic [4:0]  base;
    logic [5:0]  alu_fn [8];
    logic [5:0]  imm_op [5];
    alu_fn = '{mse_pkg::FN_ADD, mse_pkg::FN_SUB, mse_pkg::FN_AND, mse_pkg::FN_OR,
               mse_pkg::FN_NOR, mse_pkg::FN_SLT, mse_pkg::FN_SLL, mse_pkg::FN_SRL};
    imm_op = '{mse_pkg::OP_ADDI, mse_pkg::OP_SLTI, mse_pkg::OP_ANDI, mse_pkg::OP_ORI,
               mse_pkg::OP_LUI};
    pick = $urandom_range(0, 99);
    rnd = $urandom;
    if (pick < 10) begin
      send_instr(rnd);
    end else if (pick < 35) begin
      send_instr(rtype(rand_reg(), rand_reg(), rand_reg(), rnd[10:6],
                       alu_fn[3'($urandom_range(0, 7))]));
    end else if (pick < 55) begin
      send_instr(itype(imm_op[3'($urandom_range(0, 4))], rand_reg(), rand_reg(),
                       rnd[15:0]));
    end else if (pick < 70) begin
      // loads and stores mostly around a few bases so that loads hit stored data
      case ($urandom_range(0, 3))
        0:       base = mse_pkg::REG_ZERO;
        1:       base = mse_pkg::REG_GP;
        2:       base = mse_pkg::REG_SP;
        default: base = rand_reg();
      endcase
      case ($urandom_range(0, 4))
        0:       imm = rnd[15:0];
        1:       imm = 16'(16380 + $urandom_range(0, 7));
        default: imm = 16'($urandom_range(0, 127));
      endcase
      send_instr(itype($urandom_range(0, 1) ? mse_pkg::OP_LW : mse_pkg::OP_SW, base,
                       rand_reg(), imm));
    end else if (pick < 80) begin
      imm = $urandom_range(0, 3) == 0 ? rnd[15:0] : 16'($signed($urandom_range(0, 16)) - 8);
      send_instr(itype($urandom_range(0, 1) ? mse_pkg::OP_BEQ : mse_pkg::OP_BNE,
                       rand_reg(), rand_reg(), imm));
    end else if (pick < 85) begin
      send_instr(jtype($urandom_range(0, 1) ? mse_pkg::OP_J : mse_pkg::OP_JAL, rnd[25:0]));
    end else if (pick < 88) begin
      send_instr({mse_pkg::OP_SPECIAL, rand_reg(), rnd[20:6], mse_pkg::FN_JR});
    end else begin
      // load v0 with a service number, maybe a0, then call
      case ($urandom_range(0, 4))
        0:       svc = mse_pkg::SVC_DUMP[15:0];
        1:       svc = mse_pkg::SVC_PRINT_INT[15:0];
        2:       svc = mse_pkg::SVC_READ_INT[15:0];
        3:       svc = mse_pkg::SVC_EXIT[15:0];
        default: svc = rnd[15:0];
      endcase
      send_instr(itype(mse_pkg::OP_ORI, mse_pkg::REG_ZERO, mse_pkg::REG_V0, svc));
      if ($urandom_range(0, 1)) begin
        send_instr(itype(mse_pkg::OP_LUI, mse_pkg::REG_ZERO, mse_pkg::REG_A0, rnd[31:16]));
        send_instr(itype(mse_pkg::OP_ORI, mse_pkg::REG_A0, mse_pkg::REG_A0, rnd[15:0]));
      end
      rnd = $urandom;
      send_instr({mse_pkg::OP_SPECIAL, rnd[19:0], mse_pkg::FN_SYSCALL});
    end
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      while (hold_left > 0) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // long hold-off so the result queue fills and in_ready drops
  initial begin
    wait (instr_sent >= 400);
    @(posedge clk);
    hold_left = 300;
    while (hold_left > 0) begin
      @(posedge clk);
      hold_left--;
    end
  end

  // reset, directed instructions, random instructions, drain and verdict
  initial begin
    int next_phase;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register zero stays zero
    send_instr(itype(mse_pkg::OP_ADDI, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 16'hFFFF));
    // immediate extension and signed compares
    send_instr(itype(mse_pkg::OP_LUI, mse_pkg::REG_ZERO, 5'd5, 16'h8000));
    send_instr(itype(mse_pkg::OP_ORI, 5'd5, 5'd5, 16'hFFFF));
    send_instr(itype(mse_pkg::OP_ADDI, mse_pkg::REG_ZERO, 5'd6, 16'h8000));
    send_instr(itype(mse_pkg::OP_ANDI, 5'd6, 5'd7, 16'hFFFF));
    send_instr(itype(mse_pkg::OP_SLTI, 5'd5, 5'd8, 16'h0001));
    send_instr(rtype(5'd6, mse_pkg::REG_ZERO, 5'd9, 5'd0, mse_pkg::FN_SLT));
    // r-type alu, shift field ignored where unused
    send_instr(rtype(5'd5, 5'd5, 5'd10, 5'd0, mse_pkg::FN_ADD));
    send_instr(rtype(mse_pkg::REG_ZERO, 5'd5, 5'd11, 5'd0, mse_pkg::FN_SUB));
    send_instr(rtype(5'd5, 5'd6, 5'd12, 5'd0, mse_pkg::FN_AND));
    send_instr(rtype(5'd5, 5'd6, 5'd13, 5'd31, mse_pkg::FN_OR));
    send_instr(rtype(mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 5'd14, 5'd0, mse_pkg::FN_NOR));
    send_instr(rtype(mse_pkg::REG_ZERO, 5'd5, 5'd15, 5'd31, mse_pkg::FN_SLL));
    send_instr(rtype(mse_pkg::REG_ZERO, 5'd6, 5'd16, 5'd31, mse_pkg::FN_SRL));
    // last word of memory, low address bits ignored, then out of range
    send_instr(itype(mse_pkg::OP_SW, mse_pkg::REG_ZERO, 5'd5, 16'd16380));
    send_instr(itype(mse_pkg::OP_LW, mse_pkg::REG_ZERO, 5'd17, 16'd16383));
    send_instr(itype(mse_pkg::OP_SW, mse_pkg::REG_ZERO, 5'd6, 16'd16384));
    send_instr(itype(mse_pkg::OP_LW, mse_pkg::REG_ZERO, 5'd18, 16'd16384));
    // branches, jumps and link
    send_instr(itype(mse_pkg::OP_BEQ, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 16'hFFFF));
    send_instr(itype(mse_pkg::OP_BNE, 5'd5, 5'd6, 16'h8000));
    send_instr(jtype(mse_pkg::OP_JAL, 26'h3FFFFFF));
    send_instr({mse_pkg::OP_SPECIAL, mse_pkg::REG_RA, 15'h7FFF, mse_pkg::FN_JR});
    send_instr(jtype(mse_pkg::OP_J, 26'h0000000));
    // print-int syscall with junk in the other fields, then unknown codes
    send_instr(itype(mse_pkg::OP_ORI, mse_pkg::REG_ZERO, mse_pkg::REG_V0,
                     mse_pkg::SVC_PRINT_INT[15:0]));
    send_instr({mse_pkg::OP_SPECIAL, 20'hFFFFF, mse_pkg::FN_SYSCALL});
    send_instr({6'h3F, 26'h3FFFFFF});
    send_instr(rtype(5'd5, 5'd6, 5'd7, 5'd0, 6'h3F));

    // random part in phases, some of them without idling
    next_phase = instr_sent;
    while (instr_sent < TOTAL_ITEMS) begin
      if (instr_sent >= next_phase) begin
        calm = ($urandom_range(0, 3) == 0);
        next_phase = instr_sent + 150;
      end
      send_random();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (inflight != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: mips_subset_execute_unit.f
+incdir+rtl
rtl/mse_pkg.sv
rtl/mips_subset_execute_unit.sv
dv/mse_result_checker.sv
dv/tb.sv
